@@ rtl/acs_pkg.sv @@
`timescale 1ns / 1ps

package acs_pkg;

    localparam int MEM_WORDS = 4096;
    localparam int MEM_AW    = $clog2(MEM_WORDS);
    localparam int WORD_W    = 16;
    localparam int PC_W      = 12;

    localparam logic [WORD_W-1:0] OPC_MASK  = 16'hF000;
    localparam logic [WORD_W-1:0] OPR_MASK  = 16'h0FFF;
    localparam logic [WORD_W:0]   OVF_LIMIT = 17'd255;
    localparam logic [WORD_W-1:0] HALT_WORD = 16'h0000;

    localparam logic [1:0] K_WRITE   = 2'd0;
    localparam logic [1:0] K_STEP    = 2'd1;
    localparam logic [1:0] K_RESTART = 2'd2;

    typedef enum logic [3:0] {
        OP_HLT = 4'd0,
        OP_ADD = 4'd1,
        OP_SUB = 4'd2,
        OP_STA = 4'd3,
        OP_LDA = 4'd4,
        OP_BRA = 4'd5,
        OP_BRZ = 4'd6,
        OP_BRP = 4'd7,
        OP_INP = 4'd8,
        OP_OUT = 4'd9
    } op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_OPER,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [11:0] address;
        logic [15:0] write_data;
        logic [7:0]  input_value;
    } req_t;

    typedef struct packed {
        logic        out_valid;
        logic [15:0] out_value;
        logic        halted;
        logic        overflow_flag;
        logic        underflow_flag;
        logic        illegal_opcode;
        logic [11:0] program_counter;
    } rsp_t;

    typedef struct packed {
        logic [PC_W-1:0]   pc;
        logic [WORD_W-1:0] acc;
        logic              halt;
        logic              ovf;
        logic              unf;
    } cpu_state_t;

    typedef struct packed {
        cpu_state_t        nxt;
        logic              emit;
        logic [WORD_W-1:0] emit_val;
        logic              illegal;
        logic              mem_we;
        logic [PC_W-1:0]   mem_addr;
        logic [WORD_W-1:0] mem_data;
    } exec_t;

    function automatic logic addr_ok(input logic [PC_W-1:0] a);
        return ({1'b0, a} < (PC_W+1)'(MEM_WORDS));
    endfunction

endpackage

@@ rtl/acs_if.sv @@
`timescale 1ns / 1ps

interface acs_req_if;
    logic          valid;
    logic          ready;
    acs_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface acs_rsp_if;
    logic          valid;
    logic          ready;
    acs_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/acs_ram.sv @@
`timescale 1ns / 1ps

module acs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/acs_exec.sv @@
`timescale 1ns / 1ps

module acs_exec (
    input  logic [acs_pkg::WORD_W-1:0] ir,
    input  logic [acs_pkg::WORD_W-1:0] operand_data,
    input  logic [7:0]                 input_value,
    input  acs_pkg::cpu_state_t        cur,
    output acs_pkg::exec_t             ex
);
    import acs_pkg::*;

    logic [3:0]        opc;
    logic [PC_W-1:0]   opr;
    logic [PC_W-1:0]   pc_inc;
    logic [WORD_W:0]   sum;
    logic [WORD_W-1:0] diff;

    assign opc    = 4'((ir & OPC_MASK) >> 12);
    assign opr    = PC_W'(ir & OPR_MASK);
    assign pc_inc = cur.pc + PC_W'(1);
    assign sum    = {1'b0, cur.acc} + {1'b0, operand_data};
    assign diff   = cur.acc - operand_data;

    always_comb
    begin
        ex          = '0;
        ex.nxt      = cur;
        ex.nxt.pc   = pc_inc;
        ex.mem_addr = opr;
        ex.mem_data = cur.acc;
        unique case (opc)
            OP_HLT: ex.nxt.halt = 1'b1;
            OP_ADD:
            begin
                ex.nxt.ovf = (sum > OVF_LIMIT);
                ex.nxt.acc = sum[WORD_W-1:0];
            end
            OP_SUB:
            begin
                ex.nxt.unf = (operand_data > cur.acc);
                ex.nxt.acc = diff;
            end
            OP_STA: ex.mem_we = 1'b1;
            OP_LDA: ex.nxt.acc = operand_data;
            OP_BRA: ex.nxt.pc = opr;
            OP_BRZ:
            begin
                if (cur.acc == '0 && !cur.unf && !cur.ovf)
                begin
                    ex.nxt.pc = opr;
                end
            end
            OP_BRP:
            begin
                if (!cur.unf || cur.acc == '0)
                begin
                    ex.nxt.pc = opr;
                end
            end
            OP_INP: ex.nxt.acc = {8'b0, input_value};
            OP_OUT:
            begin
                ex.emit     = 1'b1;
                ex.emit_val = cur.acc;
            end
            default:
            begin
                // undefined opcode: plant a halt word at the next pc
                ex.illegal  = 1'b1;
                ex.mem_we   = 1'b1;
                ex.mem_addr = pc_inc;
                ex.mem_data = HALT_WORD;
            end
        endcase
    end

endmodule

@@ rtl/accumulator_cpu_step.sv @@
`timescale 1ns / 1ps
// write, restart and ignored requests, and steps while halted: result registered via the done state
// step: result follows fetch read, operand read and execute with write back
// a new request is taken in the execute cycle, but not after STA or an undefined opcode
// (one write port on the word memory); other requests one per cycle while the result register is free
// reset clears pc, accumulator and flags; the word memory is not cleared and has no sweep

module accumulator_cpu_step (
    input logic      clk,
    input logic      rst_n,
    acs_req_if.sink  req,
    acs_rsp_if.source rsp
);
    import acs_pkg::*;

    state_t            state_reg;
    state_t            state_next;
    cpu_state_t        cpu_reg;
    cpu_state_t        cpu_next;
    cpu_state_t        post;
    logic [WORD_W-1:0] ir_reg;
    logic [WORD_W-1:0] ir_next;
    logic [7:0]        inp_reg;
    logic              fetch_ok_reg;
    logic              oper_ok_reg;
    logic              oper_ok_next;
    logic              out_vld_reg;
    logic              out_vld_next;
    rsp_t              out_reg;
    rsp_t              out_next;

    logic              out_free;
    logic              req_fire;
    logic              exec_done;
    logic              done_emit;
    logic              step_go;
    logic [WORD_W-1:0] operand_data;
    exec_t             ex;

    logic              ram_we;
    logic [PC_W-1:0]   ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic              ram_re;
    logic [PC_W-1:0]   ram_raddr;
    logic [WORD_W-1:0] ram_rdata;
    logic              ram_we_ok;

    assign out_free     = !out_vld_reg || rsp.ready;
    assign req_fire     = req.valid && req.ready;
    assign operand_data = oper_ok_reg ? ram_rdata : '0;
    assign ir_next      = fetch_ok_reg ? ram_rdata : '0;
    assign oper_ok_next = addr_ok(ir_next[PC_W-1:0]);

    acs_exec u_exec (
        .ir           (ir_reg),
        .operand_data (operand_data),
        .input_value  (inp_reg),
        .cur          (cpu_reg),
        .ex           (ex)
    );

    acs_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MEM_WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we_ok),
        .waddr (ram_waddr[MEM_AW-1:0]),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr[MEM_AW-1:0]),
        .rdata (ram_rdata)
    );

    assign ram_we_ok = ram_we && addr_ok(ram_waddr);

    // control outputs
    always_comb
    begin
        req.ready = 1'b0;
        exec_done = 1'b0;
        done_emit = 1'b0;
        unique case (state_reg)
            S_IDLE:  req.ready = out_free;
            S_FETCH: req.ready = 1'b0;
            S_OPER:
            begin
                exec_done = out_free;
                req.ready = out_free && !ex.mem_we;
            end
            S_DONE:
            begin
                done_emit = out_free;
                req.ready = out_free;
            end
            default: req.ready = 1'b0;
        endcase
    end

    // state after the executing step, then after the new request
    always_comb
    begin
        post     = exec_done ? ex.nxt : cpu_reg;
        cpu_next = post;
        step_go  = 1'b0;
        if (req_fire)
        begin
            if (req.data.kind == K_RESTART)
            begin
                cpu_next = '0;
            end
            if (req.data.kind == K_STEP && !post.halt)
            begin
                step_go = 1'b1;
            end
        end
    end

    // memory ports
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = req.data.address;
        ram_wdata = req.data.write_data;
        ram_re    = 1'b0;
        ram_raddr = post.pc;
        if (exec_done && ex.mem_we)
        begin
            ram_we    = 1'b1;
            ram_waddr = ex.mem_addr;
            ram_wdata = ex.mem_data;
        end
        else if (req_fire && req.data.kind == K_WRITE)
        begin
            ram_we = 1'b1;
        end
        if (state_reg == S_FETCH)
        begin
            ram_re    = 1'b1;
            ram_raddr = ir_next[PC_W-1:0];
        end
        else if (step_go)
        begin
            ram_re = 1'b1;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  state_next = req_fire ? (step_go ? S_FETCH : S_DONE) : S_IDLE;
            S_FETCH: state_next = S_OPER;
            S_OPER:
            begin
                if (exec_done)
                begin
                    state_next = req_fire ? (step_go ? S_FETCH : S_DONE) : S_IDLE;
                end
            end
            S_DONE:
            begin
                if (done_emit)
                begin
                    state_next = req_fire ? (step_go ? S_FETCH : S_DONE) : S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // result register
    always_comb
    begin
        out_vld_next = out_vld_reg && !rsp.ready;
        out_next     = out_reg;
        if (exec_done)
        begin
            out_vld_next             = 1'b1;
            out_next.out_valid       = ex.emit;
            out_next.out_value       = ex.emit_val;
            out_next.halted          = ex.nxt.halt;
            out_next.overflow_flag   = ex.nxt.ovf;
            out_next.underflow_flag  = ex.nxt.unf;
            out_next.illegal_opcode  = ex.illegal;
            out_next.program_counter = ex.nxt.pc;
        end
        else if (done_emit)
        begin
            out_vld_next             = 1'b1;
            out_next.out_valid       = 1'b0;
            out_next.out_value       = '0;
            out_next.halted          = cpu_reg.halt;
            out_next.overflow_flag   = cpu_reg.ovf;
            out_next.underflow_flag  = cpu_reg.unf;
            out_next.illegal_opcode  = 1'b0;
            out_next.program_counter = cpu_reg.pc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cpu_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cpu_reg     <= cpu_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (step_go)
        begin
            inp_reg      <= req.data.input_value;
            fetch_ok_reg <= addr_ok(post.pc);
        end
        if (state_reg == S_FETCH)
        begin
            ir_reg      <= ir_next;
            oper_ok_reg <= oper_ok_next;
        end
    end

    assign rsp.valid = out_vld_reg;
    assign rsp.data  = out_reg;

    a_no_read_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !ram_re)
        else $error("word memory read and written in one cycle");

    a_step_fetches: assert property (@(posedge clk) disable iff (!rst_n)
        step_go |=> state_reg == S_FETCH)
        else $error("accepted step did not start a fetch");

    a_fetch_to_oper: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FETCH |=> state_reg == S_OPER)
        else $error("fetch not followed by execute");

    a_write_blocks_req: assert property (@(posedge clk) disable iff (!rst_n)
        (exec_done && ex.mem_we) |-> !req_fire)
        else $error("request taken while execute writes memory");

    a_illegal_not_out: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.data.illegal_opcode) |-> !rsp.data.out_valid && !rsp.data.halted)
        else $error("undefined opcode result carries output or halt");

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import acs_pkg::*;

    localparam logic [1:0] K_UNUSED = 2'd3;
    localparam logic [3:0] OPC_LAST = 4'hF;
    localparam int         DRAIN_CYCLES = 10;

    logic clk = 1'b0;
    logic rst_n;

    acs_req_if req_bus ();
    acs_rsp_if rsp_bus ();

    accumulator_cpu_step DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    always #5 clk = ~clk;

    // predicted processor state
    logic [PC_W-1:0]   cpu_pc;
    logic [WORD_W-1:0] cpu_acc;
    logic              cpu_halt;
    logic              cpu_ovf;
    logic              cpu_unf;
    logic [WORD_W-1:0] word_mem [MEM_WORDS];
    bit                word_set [MEM_WORDS];

    rsp_t expected_rsps[$];

    bit idle_on;
    bit failed;
    int items_sent;
    int results_checked;
    int steps_run;
    int outputs_seen;
    int illegal_seen;
    int restarts_seen;

    function automatic logic [WORD_W-1:0] word_read(input logic [PC_W-1:0] a);
        if ({1'b0, a} < MEM_WORDS)
        begin
            return word_mem[a];
        end
        return '0;
    endfunction

    function automatic void word_write(input logic [PC_W-1:0] a, input logic [WORD_W-1:0] v);
        if ({1'b0, a} < MEM_WORDS)
        begin
            word_mem[a] = v;
            word_set[a] = 1'b1;
        end
    endfunction

    function automatic void clear_cpu();
        cpu_pc   = '0;
        cpu_acc  = '0;
        cpu_halt = 1'b0;
        cpu_ovf  = 1'b0;
        cpu_unf  = 1'b0;
    endfunction

    function automatic rsp_t cpu_apply(input req_t r);
        rsp_t              o;
        logic [WORD_W-1:0] word;
        logic [WORD_W-1:0] m;
        logic [WORD_W:0]   sum;
        logic [PC_W-1:0]   opr;
        o = '0;
        case (r.kind)
            K_WRITE: word_write(r.address, r.write_data);
            K_STEP:
            begin
                if (!cpu_halt)
                begin
                    word = word_read(cpu_pc);
                    opr = word[PC_W-1:0];
                    cpu_pc = cpu_pc + PC_W'(1);
                    steps_run++;
                    case (word[15:12])
                        OP_HLT: cpu_halt = 1'b1;
                        OP_ADD:
                        begin
                            m = word_read(opr);
                            sum = {1'b0, cpu_acc} + {1'b0, m};
                            cpu_ovf = sum > OVF_LIMIT;
                            cpu_acc = sum[WORD_W-1:0];
                        end
                        OP_SUB:
                        begin
                            m = word_read(opr);
                            cpu_unf = m > cpu_acc;
                            cpu_acc = cpu_acc - m;
                        end
                        OP_STA: word_write(opr, cpu_acc);
                        OP_LDA: cpu_acc = word_read(opr);
                        OP_BRA: cpu_pc = opr;
                        OP_BRZ:
                        begin
                            if (cpu_acc == '0 && !cpu_unf && !cpu_ovf)
                            begin
                                cpu_pc = opr;
                            end
                        end
                        OP_BRP:
                        begin
                            if (!cpu_unf || cpu_acc == '0)
                            begin
                                cpu_pc = opr;
                            end
                        end
                        OP_INP: cpu_acc = {8'h00, r.input_value};
                        OP_OUT:
                        begin
                            o.out_valid = 1'b1;
                            o.out_value = cpu_acc;
                            outputs_seen++;
                        end
                        default:
                        begin
                            // halt word lands at the next pc, which is not skipped
                            word_write(cpu_pc, HALT_WORD);
                            o.illegal_opcode = 1'b1;
                            illegal_seen++;
                        end
                    endcase
                end
            end
            K_RESTART:
            begin
                clear_cpu();
                restarts_seen++;
            end
            default: ;
        endcase
        o.halted          = cpu_halt;
        o.overflow_flag   = cpu_ovf;
        o.underflow_flag  = cpu_unf;
        o.program_counter = cpu_pc;
        return o;
    endfunction

    task automatic send_request(input req_t r);
        while (idle_on && $urandom_range(99) < 36)
        begin
            req_bus.valid <= 1'b0;
            @(negedge clk);
        end
        req_bus.valid <= 1'b1;
        req_bus.data  <= r;
        do
            @(posedge clk);
        while (!req_bus.ready);
        expected_rsps.push_back(cpu_apply(r));
        items_sent++;
        @(negedge clk);
    endtask

    task automatic write_word(input logic [PC_W-1:0] a, input logic [WORD_W-1:0] v);
        req_t r;
        r = '0;
        r.kind        = K_WRITE;
        r.address     = a;
        r.write_data  = v;
        r.input_value = 8'($urandom_range(255));
        send_request(r);
    endtask

    task automatic run_step(input logic [7:0] in_byte);
        req_t r;
        r.kind        = K_STEP;
        r.address     = PC_W'($urandom_range(MEM_WORDS - 1));
        r.write_data  = WORD_W'($urandom);
        r.input_value = in_byte;
        send_request(r);
    endtask

    task automatic restart_regs();
        req_t r;
        r.kind        = K_RESTART;
        r.address     = PC_W'($urandom_range(MEM_WORDS - 1));
        r.write_data  = WORD_W'($urandom);
        r.input_value = 8'($urandom_range(255));
        send_request(r);
    endtask

    task automatic ignored_item();
        req_t r;
        r.kind        = K_UNUSED;
        r.address     = PC_W'($urandom_range(MEM_WORDS - 1));
        r.write_data  = WORD_W'($urandom);
        r.input_value = 8'($urandom_range(255));
        send_request(r);
    endtask

    function automatic logic [PC_W-1:0] random_operand();
        int roll;
        roll = $urandom_range(99);
        if (roll < 50)
        begin
            return PC_W'($urandom_range(63));
        end
        else if (roll < 60)
        begin
            return PC_W'($urandom_range(MEM_WORDS - 1, MEM_WORDS - 64));
        end
        return PC_W'($urandom_range(MEM_WORDS - 1));
    endfunction

    function automatic logic [WORD_W-1:0] random_instruction();
        logic [3:0] opc;
        int         roll;
        roll = $urandom_range(99);
        if (roll < 5)
        begin
            opc = 4'($urandom_range(OPC_LAST, OP_OUT + 1));
        end
        else if (roll < 8)
        begin
            opc = OP_HLT;
        end
        else
        begin
            opc = 4'($urandom_range(OP_OUT, OP_ADD));
        end
        return {opc, random_operand()};
    endfunction

    // data word biased toward zero results and the overflow boundary
    function automatic logic [WORD_W-1:0] random_data();
        int roll;
        roll = $urandom_range(99);
        if (roll < 30)
        begin
            return cpu_acc;
        end
        else if (roll < 60)
        begin
            return WORD_W'($urandom_range(255));
        end
        else if (roll < 75)
        begin
            return 16'(256 - cpu_acc);
        end
        return WORD_W'($urandom);
    endfunction

    // make sure the step fetches and reads only written words
    task automatic prepare_step();
        logic [WORD_W-1:0] word;
        if (!cpu_halt)
        begin
            if (!word_set[cpu_pc] || $urandom_range(99) < 50)
            begin
                write_word(cpu_pc, random_instruction());
            end
            word = word_mem[cpu_pc];
            if ((word[15:12] == OP_ADD || word[15:12] == OP_SUB || word[15:12] == OP_LDA)
                && !word_set[word[PC_W-1:0]])
            begin
                write_word(word[PC_W-1:0], random_data());
            end
        end
    endtask

    task automatic test_directed_program();
        idle_on = 1'b1;
        write_word(12'h000, {OP_INP, 12'h000});
        write_word(12'h001, {OP_ADD, 12'h000});
        write_word(12'h002, {OP_SUB, 12'h101});
        write_word(12'h003, {OP_STA, 12'hFFF});
        write_word(12'h004, {OP_LDA, 12'hFFF});
        write_word(12'h005, {OP_OUT, 12'h000});
        write_word(12'h006, {OP_BRP, 12'h000});
        write_word(12'h007, {OP_BRZ, 12'h000});
        write_word(12'h008, {OP_BRA, 12'h101});
        write_word(12'h101, 16'hFFFF);
        // runs through every opcode, an undefined one, its halt and a halted step
        repeat (12) run_step(8'hFF);
        ignored_item();
        restart_regs();
    endtask

    task automatic test_random_programs(input int n_items, input bit gaps);
        int first_item;
        int roll;
        idle_on = gaps;
        first_item = items_sent;
        while (items_sent - first_item < n_items)
        begin
            roll = $urandom_range(99);
            if (cpu_halt && roll < 50)
            begin
                restart_regs();
            end
            else if (roll < 5)
            begin
                ignored_item();
            end
            else if (roll < 9)
            begin
                restart_regs();
            end
            else if (roll < 18)
            begin
                write_word(PC_W'($urandom_range(MEM_WORDS - 1)), WORD_W'($urandom));
            end
            else
            begin
                prepare_step();
                run_step(8'($urandom_range(255)));
            end
        end
    endtask

    task automatic compare_field(input string field, input logic [15:0] exp_v,
                                 input logic [15:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, act_v);
            failed = 1'b1;
        end
    endtask

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            rsp_bus.ready <= !idle_on || ($urandom_range(99) >= 36);
        end
    end

    always @(posedge clk)
    begin
        rsp_t exp_r;
        if (rsp_bus.valid && rsp_bus.ready)
        begin
            if (expected_rsps.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, rsp_bus.data);
                failed = 1'b1;
            end
            else
            begin
                exp_r = expected_rsps.pop_front();
                results_checked++;
                compare_field("out_valid", 16'(exp_r.out_valid),
                              16'(rsp_bus.data.out_valid));
                compare_field("out_value", exp_r.out_value, rsp_bus.data.out_value);
                compare_field("halted", 16'(exp_r.halted), 16'(rsp_bus.data.halted));
                compare_field("overflow_flag", 16'(exp_r.overflow_flag),
                              16'(rsp_bus.data.overflow_flag));
                compare_field("underflow_flag", 16'(exp_r.underflow_flag),
                              16'(rsp_bus.data.underflow_flag));
                compare_field("illegal_opcode", 16'(exp_r.illegal_opcode),
                              16'(rsp_bus.data.illegal_opcode));
                compare_field("program_counter", 16'(exp_r.program_counter),
                              16'(rsp_bus.data.program_counter));
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        req_bus.valid = 1'b0;
        req_bus.data  = '0;
        rsp_bus.ready = 1'b0;
        idle_on       = 1'b1;
        clear_cpu();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_program();
        test_random_programs(500, 1'b0);
        test_random_programs(1500, 1'b1);

        req_bus.valid <= 1'b0;
        while (expected_rsps.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("ran %0d instruction steps: %0d outputs, %0d undefined opcodes, %0d restarts",
                 steps_run, outputs_seen, illegal_seen, restarts_seen);
        $display("%0d requests, %0d results compared field by field, with and without gaps",
                 items_sent, results_checked);
        if (!failed)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/acs_pkg.sv
rtl/acs_if.sv
rtl/acs_ram.sv
rtl/acs_exec.sv
rtl/accumulator_cpu_step.sv
tb/sv/tb.sv
